// ===== hw/rtl/prs_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prs_pkg
// Shared widths, codes and reset values of the power rail sequencer.
// ----------------------------------------------------------------------------
package prs_pkg;

    localparam int RAIL_W  = 16;
    localparam int GOOD_W  = 16;
    localparam int PRIO_W  = 48;
    localparam int LVL_W   = 3;
    localparam int ST_W    = 3;
    localparam int DELAY_W = 16;
    localparam int FUNC_W  = 3;
    localparam int IDX_W   = 5;
    localparam int CFG_W   = 48;
    localparam int CFGI_W  = 2;

    localparam int DEF_NUM_RAILS  = 16;
    localparam int DEF_NUM_GOODS  = 16;
    localparam int DEF_NUM_LEVELS = 6;

    localparam logic [DELAY_W-1:0] OFF_DELAY_RST = DELAY_W'(500);
    localparam logic               REQ_BLADE_RST = 1'b1;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK       = 3'd0,
        FN_POWER_ON   = 3'd1,
        FN_POWER_OFF  = 3'd2,
        FN_LEVEL_ON   = 3'd3,
        FN_SET_STATUS = 3'd4,
        FN_WRITE_OK   = 3'd5
    } func_t;

    typedef enum logic [CFGI_W-1:0] {
        CFG_RAIL_PRIO = 2'd0,
        CFG_GOOD_PRIO = 2'd1,
        CFG_OFF_DELAY = 2'd2,
        CFG_REQ_BLADE = 2'd3
    } cfg_idx_t;

    localparam logic [ST_W-1:0] ST_UNKNOWN  = 3'd0;
    localparam logic [ST_W-1:0] ST_OFF      = 3'd1;
    localparam logic [ST_W-1:0] ST_DISABLED = 3'd2;

    typedef struct packed {
        logic [RAIL_W-1:0] rail_enable_bits;
        logic              pwr_ok;
        logic [ST_W-1:0]   status_read;
        logic              busy_res;
        logic              accepted;
    } result_t;

endpackage

// ===== hw/rtl/power_rail_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// power_rail_sequencer_top
// Rail enable / power-ok sequencer with timed, level-ordered power-off.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------
//  s_      | in        | s_valid / s_ready  | func, mask, goods, level, ...
//  m_      | out       | m_valid / m_ready  | rails, pwr_ok, status, ...
//  cfg_    | in        | cfg_wr_en          | cfg_index, cfg_wdata
//
//  One beat per cycle while s_ready is high; state updates at the input beat.
//  The result goes to an output reg + skid reg,
//  so s_ready only drops when both hold a beat.
//  Reset clears rails, power-ok, statuses and the off sequence; no sweep.
// ----------------------------------------------------------------------------
module power_rail_sequencer_top #(
    parameter int NUM_RAILS  = prs_pkg::DEF_NUM_RAILS,
    parameter int NUM_GOODS  = prs_pkg::DEF_NUM_GOODS,
    parameter int NUM_LEVELS = prs_pkg::DEF_NUM_LEVELS
) (
    input  logic                        aclk,
    input  logic                        aresetn,

    input  logic                        cfg_wr_en,
    input  logic [prs_pkg::CFGI_W-1:0]  cfg_index,
    input  logic [prs_pkg::CFG_W-1:0]   cfg_wdata,

    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [prs_pkg::FUNC_W-1:0]  s_func,
    input  logic [prs_pkg::RAIL_W-1:0]  s_rail_mask,
    input  logic                        s_blade_enable,
    input  logic [prs_pkg::GOOD_W-1:0]  s_good_bits,
    input  logic [prs_pkg::LVL_W-1:0]   s_level,
    input  logic [prs_pkg::IDX_W-1:0]   s_index,
    input  logic [prs_pkg::ST_W-1:0]    s_new_status,
    input  logic                        s_ok_value,

    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [prs_pkg::RAIL_W-1:0]  m_rail_enable_bits,
    output logic                        m_pwr_ok,
    output logic [prs_pkg::ST_W-1:0]    m_status_read,
    output logic                        m_busy_res,
    output logic                        m_accepted
);
    import prs_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE   = 2'd0,
        PH_DELAY  = 2'd1,
        PH_LEVELS = 2'd2
    } phase_t;

    // configuration
    logic [PRIO_W-1:0]  rail_prio_reg;
    logic [PRIO_W-1:0]  good_prio_reg;
    logic [DELAY_W-1:0] off_delay_reg;
    logic               req_blade_reg;

    // sequencer state
    logic [RAIL_W-1:0]  rail_enable_reg, rail_enable_next;
    logic               pwr_ok_reg, pwr_ok_next;
    logic [ST_W-1:0]    status_reg [NUM_GOODS];
    logic [ST_W-1:0]    status_next [NUM_GOODS];
    logic [LVL_W-1:0]   off_level_reg, off_level_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    phase_t             phase_reg, phase_next;

    // output stage
    logic               m_valid_reg, skid_valid_reg;
    result_t            m_data_reg, skid_data_reg;
    result_t            res;

    logic               accept;
    logic               busy;
    logic [RAIL_W-1:0]  on_mask, lvl_mask, top_mask, down_mask;
    logic [GOOD_W-1:0]  bad_goods;
    logic [LVL_W-1:0]   lvl_dn;
    logic [DELAY_W-1:0] delay_dec;
    logic [ST_W-1:0]    rd_status;
    logic               acc;

    assign accept    = s_valid && s_ready;
    assign s_ready   = !skid_valid_reg;
    assign busy      = (phase_reg != PH_IDLE);
    assign lvl_dn    = off_level_reg - LVL_W'(1);
    assign delay_dec = delay_count_reg - DELAY_W'(1);

    // per-rail and per-good level compares
    always_comb begin
        on_mask   = '0;
        lvl_mask  = '0;
        top_mask  = '0;
        down_mask = '0;
        bad_goods = '0;
        for (int e = 0; e < NUM_RAILS; e++) begin
            on_mask[e]   = (rail_prio_reg[3*e +: 3] != '0) &&
                           (rail_prio_reg[3*e +: 3] <= LVL_W'(NUM_LEVELS));
            lvl_mask[e]  = (rail_prio_reg[3*e +: 3] == s_level);
            top_mask[e]  = (rail_prio_reg[3*e +: 3] == LVL_W'(NUM_LEVELS));
            down_mask[e] = (rail_prio_reg[3*e +: 3] == lvl_dn);
        end
        for (int o = 0; o < NUM_GOODS; o++) begin
            bad_goods[o] = (good_prio_reg[3*o +: 3] != '0) &&
                           (good_prio_reg[3*o +: 3] >= off_level_reg) &&
                           s_good_bits[o];
        end
    end

    // command decode and next state
    always_comb begin
        rail_enable_next = rail_enable_reg;
        pwr_ok_next      = pwr_ok_reg;
        off_level_next   = off_level_reg;
        delay_count_next = delay_count_reg;
        phase_next       = phase_reg;
        acc              = 1'b1;
        for (int o = 0; o < NUM_GOODS; o++) begin
            status_next[o] = status_reg[o];
        end

        case (s_func)
            FN_TICK: begin
                if (phase_reg == PH_DELAY) begin
                    delay_count_next = delay_dec;
                    if (delay_dec == '0) begin
                        off_level_next   = LVL_W'(NUM_LEVELS);
                        phase_next       = PH_LEVELS;
                        rail_enable_next = rail_enable_reg & ~top_mask;
                    end
                end else if (phase_reg == PH_LEVELS) begin
                    if (bad_goods != '0) begin
                        for (int o = 0; o < NUM_GOODS; o++) begin
                            if (bad_goods[o]) begin
                                status_next[o] = ST_UNKNOWN;
                            end
                        end
                    end else begin
                        off_level_next = lvl_dn;
                        if (lvl_dn == '0) begin
                            pwr_ok_next = 1'b0;
                            phase_next  = PH_IDLE;
                        end else begin
                            rail_enable_next = rail_enable_reg & ~down_mask;
                        end
                    end
                end
            end
            FN_SET_STATUS: begin
                for (int o = 0; o < NUM_GOODS; o++) begin
                    if (s_index == IDX_W'(o)) begin
                        status_next[o] = s_new_status;
                    end
                end
            end
            FN_POWER_ON: begin
                if (busy) begin
                    acc = 1'b0;
                end else if (req_blade_reg && !s_blade_enable) begin
                    pwr_ok_next = 1'b0;
                    acc         = 1'b0;
                end else begin
                    rail_enable_next = rail_enable_reg | (on_mask & s_rail_mask);
                    pwr_ok_next      = 1'b1;
                end
            end
            FN_POWER_OFF: begin
                if (busy) begin
                    acc = 1'b0;
                end else begin
                    for (int o = 0; o < NUM_GOODS; o++) begin
                        if (status_reg[o] != ST_DISABLED) begin
                            status_next[o] = ST_OFF;
                        end
                    end
                    delay_count_next = off_delay_reg;
                    if (off_delay_reg == '0) begin
                        off_level_next   = LVL_W'(NUM_LEVELS);
                        phase_next       = PH_LEVELS;
                        rail_enable_next = rail_enable_reg & ~top_mask;
                    end else begin
                        phase_next = PH_DELAY;
                    end
                end
            end
            FN_LEVEL_ON: begin
                if (busy) begin
                    acc = 1'b0;
                end else if (s_level != '0) begin
                    rail_enable_next = rail_enable_reg | lvl_mask;
                end
            end
            FN_WRITE_OK: begin
                if (busy) begin
                    acc = 1'b0;
                end else begin
                    pwr_ok_next = s_ok_value;
                end
            end
            default: begin
                acc = 1'b0;
            end
        endcase
    end

    // status read after update
    always_comb begin
        rd_status = ST_UNKNOWN;
        for (int o = 0; o < NUM_GOODS; o++) begin
            if (s_index == IDX_W'(o)) begin
                rd_status = status_next[o];
            end
        end
    end

    always_comb begin
        res.rail_enable_bits = rail_enable_next;
        res.pwr_ok           = pwr_ok_next;
        res.status_read      = rd_status;
        res.busy_res         = (phase_next != PH_IDLE);
        res.accepted         = acc;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rail_prio_reg   <= '0;
            good_prio_reg   <= '0;
            off_delay_reg   <= OFF_DELAY_RST;
            req_blade_reg   <= REQ_BLADE_RST;
            rail_enable_reg <= '0;
            pwr_ok_reg      <= 1'b0;
            off_level_reg   <= '0;
            delay_count_reg <= '0;
            phase_reg       <= PH_IDLE;
            m_valid_reg     <= 1'b0;
            skid_valid_reg  <= 1'b0;
            for (int o = 0; o < NUM_GOODS; o++) begin
                status_reg[o] <= ST_UNKNOWN;
            end
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    CFG_RAIL_PRIO: rail_prio_reg <= cfg_wdata[PRIO_W-1:0];
                    CFG_GOOD_PRIO: good_prio_reg <= cfg_wdata[PRIO_W-1:0];
                    CFG_OFF_DELAY: off_delay_reg <= cfg_wdata[DELAY_W-1:0];
                    CFG_REQ_BLADE: req_blade_reg <= cfg_wdata[0];
                    default: ;
                endcase
            end

            if (accept) begin
                rail_enable_reg <= rail_enable_next;
                pwr_ok_reg      <= pwr_ok_next;
                off_level_reg   <= off_level_next;
                delay_count_reg <= delay_count_next;
                phase_reg       <= phase_next;
                for (int o = 0; o < NUM_GOODS; o++) begin
                    status_reg[o] <= status_next[o];
                end
            end

            if (!m_valid_reg || m_ready) begin
                if (skid_valid_reg) begin
                    m_valid_reg    <= 1'b1;
                    m_data_reg     <= skid_data_reg;
                    skid_valid_reg <= 1'b0;
                end else begin
                    m_valid_reg <= accept;
                    if (accept) begin
                        m_data_reg <= res;
                    end
                end
            end else if (accept) begin
                skid_valid_reg <= 1'b1;
                skid_data_reg  <= res;
            end
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_rail_enable_bits = m_data_reg.rail_enable_bits;
    assign m_pwr_ok           = m_data_reg.pwr_ok;
    assign m_status_read      = m_data_reg.status_read;
    assign m_busy_res         = m_data_reg.busy_res;
    assign m_accepted         = m_data_reg.accepted;

    // skid holds a beat only behind a held output beat
    a_skid_behind_out: assert property (@(posedge aclk) disable iff (!aresetn)
        skid_valid_reg |-> m_valid_reg)
        else $error("skid beat without output beat");

    a_stall_fills_skid: assert property (@(posedge aclk) disable iff (!aresetn)
        (accept && m_valid_reg && !m_ready) |=> skid_valid_reg)
        else $error("beat lost on output stall");

    a_levels_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_LEVELS) |->
            (off_level_reg != '0 && off_level_reg <= LVL_W'(NUM_LEVELS)))
        else $error("off level out of range");

    a_idle_level: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (off_level_reg == '0))
        else $error("off level left set while idle");

    a_delay_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_DELAY) |-> (delay_count_reg != '0))
        else $error("delay phase with zero count");

endmodule

// ===== tb/tb_power_rail_sequencer_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_power_rail_sequencer_top
// Self-checking bench for the power rail sequencer. A directed list of beats
// and register writes runs first. Seeded random phases follow, each with its
// own register setting. An in-bench predictor mirrors the rail, power-ok,
// status and power-off state.
// Every result beat is compared field by field, in order, with its prediction.
// ----------------------------------------------------------------------------
module tb_power_rail_sequencer_top;
    import prs_pkg::*;

    localparam int NUM_RAILS  = DEF_NUM_RAILS;
    localparam int NUM_GOODS  = DEF_NUM_GOODS;
    localparam int NUM_LEVELS = DEF_NUM_LEVELS;

    localparam logic [FUNC_W-1:0] FN_UNDEF_LO = 3'd6;
    localparam logic [FUNC_W-1:0] FN_UNDEF_HI = 3'd7;

    localparam int RAND_PHASES     = 8;
    localparam int BEATS_PER_PHASE = 230;
    localparam int HOLD_PHASE      = 2;
    localparam int HOLD_CYCLES     = 64;
    localparam int MAX_SHOWN       = 10;
    localparam int TIMEOUT_NS      = 4_000_000;

    typedef enum logic [1:0] {
        SEQ_IDLE   = 2'd0,
        SEQ_DELAY  = 2'd1,
        SEQ_LEVELS = 2'd2
    } seq_phase_t;

    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [RAIL_W-1:0] rail_mask;
        logic              blade_enable;
        logic [GOOD_W-1:0] good_bits;
        logic [LVL_W-1:0]  level;
        logic [IDX_W-1:0]  index;
        logic [ST_W-1:0]   new_status;
        logic              ok_value;
    } beat_t;

    typedef struct {
        bit                is_cfg;
        cfg_idx_t          cfg_sel;
        logic [CFG_W-1:0]  cfg_val;
        beat_t             beat;
        bit                typed;
        result_t           want;
    } step_row_t;

    logic                aclk           = 1'b0;
    logic                aresetn        = 1'b0;
    logic                cfg_wr_en      = 1'b0;
    logic [CFGI_W-1:0]   cfg_index      = '0;
    logic [CFG_W-1:0]    cfg_wdata      = '0;
    logic                s_valid        = 1'b0;
    logic                s_ready;
    logic [FUNC_W-1:0]   s_func         = '0;
    logic [RAIL_W-1:0]   s_rail_mask    = '0;
    logic                s_blade_enable = 1'b0;
    logic [GOOD_W-1:0]   s_good_bits    = '0;
    logic [LVL_W-1:0]    s_level        = '0;
    logic [IDX_W-1:0]    s_index        = '0;
    logic [ST_W-1:0]     s_new_status   = '0;
    logic                s_ok_value     = 1'b0;
    logic                m_valid;
    logic                m_ready        = 1'b0;
    logic [RAIL_W-1:0]   m_rail_enable_bits;
    logic                m_pwr_ok;
    logic [ST_W-1:0]     m_status_read;
    logic                m_busy_res;
    logic                m_accepted;

    // predicted block state and registers
    logic [RAIL_W-1:0]   pr_rails;
    logic                pr_ok;
    logic [ST_W-1:0]     pr_status [NUM_GOODS];
    logic [LVL_W-1:0]    seq_level;
    logic [DELAY_W-1:0]  seq_delay;
    seq_phase_t          seq_phase;
    logic [PRIO_W-1:0]   cf_rail_prio;
    logic [PRIO_W-1:0]   cf_good_prio;
    logic [DELAY_W-1:0]  cf_off_delay;
    logic                cf_req_blade;

    result_t             want_q [$];
    step_row_t           dir_rows [$];
    int                  err_cnt  = 0;
    bit                  quiet    = 1'b0;
    bit                  hold_req = 1'b0;

    power_rail_sequencer_top dut (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cfg_wr_en          (cfg_wr_en),
        .cfg_index          (cfg_index),
        .cfg_wdata          (cfg_wdata),
        .s_valid            (s_valid),
        .s_ready            (s_ready),
        .s_func             (s_func),
        .s_rail_mask        (s_rail_mask),
        .s_blade_enable     (s_blade_enable),
        .s_good_bits        (s_good_bits),
        .s_level            (s_level),
        .s_index            (s_index),
        .s_new_status       (s_new_status),
        .s_ok_value         (s_ok_value),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_rail_enable_bits (m_rail_enable_bits),
        .m_pwr_ok           (m_pwr_ok),
        .m_status_read      (m_status_read),
        .m_busy_res         (m_busy_res),
        .m_accepted         (m_accepted)
    );

    always #2 aclk = ~aclk;

    function automatic logic [RAIL_W-1:0] rails_at_level(logic [LVL_W-1:0] lvl);
        logic [RAIL_W-1:0] m;
        m = '0;
        for (int e = 0; e < NUM_RAILS; e++) begin
            if (cf_rail_prio[3*e +: 3] == lvl) m[e] = 1'b1;
        end
        return m;
    endfunction

    function automatic void drop_top_level();
        seq_level = LVL_W'(NUM_LEVELS);
        seq_phase = SEQ_LEVELS;
        pr_rails  = pr_rails & ~rails_at_level(seq_level);
    endfunction

    function automatic result_t apply_beat(beat_t b);
        result_t           r;
        logic              busy;
        logic              settled;
        logic [RAIL_W-1:0] m;
        logic [LVL_W-1:0]  p;
        busy       = (seq_phase != SEQ_IDLE);
        r.accepted = 1'b1;
        if (b.func == FN_TICK) begin
            if (seq_phase == SEQ_DELAY) begin
                seq_delay = seq_delay - 1'b1;
                if (seq_delay == '0) drop_top_level();
            end else if (seq_phase == SEQ_LEVELS) begin
                settled = 1'b1;
                for (int o = 0; o < NUM_GOODS; o++) begin
                    p = cf_good_prio[3*o +: 3];
                    if (p != '0 && p >= seq_level && b.good_bits[o]) begin
                        settled      = 1'b0;
                        pr_status[o] = ST_UNKNOWN;
                    end
                end
                if (settled) begin
                    seq_level = seq_level - 1'b1;
                    if (seq_level == '0) begin
                        pr_ok     = 1'b0;
                        seq_phase = SEQ_IDLE;
                    end else begin
                        pr_rails = pr_rails & ~rails_at_level(seq_level);
                    end
                end
            end
        end else if (b.func == FN_SET_STATUS) begin
            if (b.index < NUM_GOODS) pr_status[b.index] = b.new_status;
        end else if (b.func > FN_WRITE_OK || busy) begin
            r.accepted = 1'b0;
        end else if (b.func == FN_POWER_ON) begin
            if (cf_req_blade && !b.blade_enable) begin
                pr_ok      = 1'b0;
                r.accepted = 1'b0;
            end else begin
                m = '0;
                for (int e = 0; e < NUM_RAILS; e++) begin
                    p = cf_rail_prio[3*e +: 3];
                    if (p != '0 && p <= NUM_LEVELS) m[e] = 1'b1;
                end
                pr_rails = pr_rails | (m & b.rail_mask);
                pr_ok    = 1'b1;
            end
        end else if (b.func == FN_POWER_OFF) begin
            for (int o = 0; o < NUM_GOODS; o++) begin
                if (pr_status[o] != ST_DISABLED) pr_status[o] = ST_OFF;
            end
            seq_delay = cf_off_delay;
            if (seq_delay == '0) drop_top_level();
            else seq_phase = SEQ_DELAY;
        end else if (b.func == FN_LEVEL_ON) begin
            if (b.level != '0) pr_rails = pr_rails | rails_at_level(b.level);
        end else begin
            pr_ok = b.ok_value;
        end
        r.rail_enable_bits = pr_rails;
        r.pwr_ok           = pr_ok;
        r.status_read      = ST_UNKNOWN;
        if (b.index < NUM_GOODS) r.status_read = pr_status[b.index];
        r.busy_res         = (seq_phase != SEQ_IDLE);
        return r;
    endfunction

    function automatic beat_t mk_beat(logic [FUNC_W-1:0] fn, logic [RAIL_W-1:0] mask,
                                      logic blade, logic [GOOD_W-1:0] goods,
                                      logic [LVL_W-1:0] lvl, logic [IDX_W-1:0] idx,
                                      logic [ST_W-1:0] nst, logic okv);
        beat_t b;
        b.func         = fn;
        b.rail_mask    = mask;
        b.blade_enable = blade;
        b.good_bits    = goods;
        b.level        = lvl;
        b.index        = idx;
        b.new_status   = nst;
        b.ok_value     = okv;
        return b;
    endfunction

    function automatic step_row_t beat_row(beat_t b, bit typed, result_t want);
        step_row_t s;
        s.is_cfg  = 1'b0;
        s.cfg_sel = CFG_RAIL_PRIO;
        s.cfg_val = '0;
        s.beat    = b;
        s.typed   = typed;
        s.want    = want;
        return s;
    endfunction

    function automatic step_row_t cfg_row(cfg_idx_t sel, logic [CFG_W-1:0] val);
        step_row_t s;
        s         = beat_row('0, 1'b0, '0);
        s.is_cfg  = 1'b1;
        s.cfg_sel = sel;
        s.cfg_val = val;
        return s;
    endfunction

    function automatic beat_t rand_beat();
        beat_t b;
        int    pick;
        b.rail_mask    = RAIL_W'($urandom);
        b.blade_enable = ($urandom_range(0, 99) < 85);
        pick           = $urandom_range(0, 9);
        if (pick < 5)      b.good_bits = '0;
        else if (pick < 8) b.good_bits = GOOD_W'($urandom & $urandom & $urandom);
        else               b.good_bits = GOOD_W'($urandom);
        b.level        = LVL_W'($urandom_range(0, 7));
        b.index        = ($urandom_range(0, 3) != 0) ? IDX_W'($urandom_range(0, 15))
                                                     : IDX_W'($urandom_range(16, 31));
        b.new_status   = ST_W'($urandom_range(0, 7));
        b.ok_value     = 1'($urandom_range(0, 1));
        pick           = $urandom_range(0, 99);
        if (seq_phase != SEQ_IDLE) begin
            if (pick < 85) b.func = FN_TICK;
            else b.func = FUNC_W'($urandom_range(int'(FN_POWER_ON), int'(FN_UNDEF_HI)));
        end else begin
            if (pick < 10)      b.func = FN_TICK;
            else if (pick < 30) b.func = FN_POWER_ON;
            else if (pick < 45) b.func = FN_POWER_OFF;
            else if (pick < 60) b.func = FN_LEVEL_ON;
            else if (pick < 75) b.func = FN_SET_STATUS;
            else if (pick < 88) b.func = FN_WRITE_OK;
            else if (pick < 94) b.func = FN_UNDEF_LO;
            else                b.func = FN_UNDEF_HI;
        end
        return b;
    endfunction

    task automatic log_err(string msg);
        err_cnt++;
        if (err_cnt <= MAX_SHOWN) $display("%0t ns: %s", $realtime, msg);
    endtask

    task automatic send_beat(beat_t b, bit typed, result_t typed_res);
        result_t r;
        @(negedge aclk);
        s_valid        <= 1'b1;
        s_func         <= b.func;
        s_rail_mask    <= b.rail_mask;
        s_blade_enable <= b.blade_enable;
        s_good_bits    <= b.good_bits;
        s_level        <= b.level;
        s_index        <= b.index;
        s_new_status   <= b.new_status;
        s_ok_value     <= b.ok_value;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        r = apply_beat(b);
        want_q.push_back(typed ? typed_res : r);
    endtask

    task automatic maybe_idle();
        int n;
        if (!quiet && $urandom_range(0, 9) < 3) begin
            n = $urandom_range(1, 6);
            repeat (n) begin
                @(negedge aclk);
                s_valid <= 1'b0;
            end
        end
    endtask

    // registers only change once every result is back
    task automatic write_cfg(cfg_idx_t sel, logic [CFG_W-1:0] val);
        @(negedge aclk);
        s_valid <= 1'b0;
        while (want_q.size() != 0) @(negedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_index <= sel;
        cfg_wdata <= val;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        case (sel)
            CFG_RAIL_PRIO: cf_rail_prio = val[PRIO_W-1:0];
            CFG_GOOD_PRIO: cf_good_prio = val[PRIO_W-1:0];
            CFG_OFF_DELAY: cf_off_delay = val[DELAY_W-1:0];
            CFG_REQ_BLADE: cf_req_blade = val[0];
            default: ;
        endcase
    endtask

    always @(posedge aclk) begin : result_check
        result_t got;
        result_t want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_rail_enable_bits, m_pwr_ok, m_status_read, m_busy_res, m_accepted};
            if (want_q.size() == 0) begin
                log_err($sformatf("unexpected result beat rails=%h ok=%b st=%0d busy=%b acc=%b",
                                  got.rail_enable_bits, got.pwr_ok, got.status_read,
                                  got.busy_res, got.accepted));
            end else begin
                want = want_q.pop_front();
                if (got.rail_enable_bits !== want.rail_enable_bits ||
                    got.pwr_ok !== want.pwr_ok || got.status_read !== want.status_read ||
                    got.busy_res !== want.busy_res || got.accepted !== want.accepted) begin
                    log_err($sformatf({"mismatch want rails=%h ok=%b st=%0d busy=%b acc=%b",
                                       " got rails=%h ok=%b st=%0d busy=%b acc=%b"},
                                      want.rail_enable_bits, want.pwr_ok, want.status_read,
                                      want.busy_res, want.accepted,
                                      got.rail_enable_bits, got.pwr_ok, got.status_read,
                                      got.busy_res, got.accepted));
                end
            end
        end
    end

    initial begin : rx_side
        int n;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (hold_req) begin
                // long back-pressure so the output stage fills and s_ready drops
                hold_req = 1'b0;
                m_ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge aclk);
            end else if (!quiet && $urandom_range(0, 9) < 3) begin
                n = $urandom_range(1, 6);
                m_ready <= 1'b0;
                repeat (n - 1) @(negedge aclk);
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin : stimulus
        logic [CFG_W-1:0]  rp;
        logic [CFG_W-1:0]  gp;
        logic [DELAY_W-1:0] dly;
        logic              rb;

        pr_rails     = '0;
        pr_ok        = 1'b0;
        seq_level    = '0;
        seq_delay    = '0;
        seq_phase    = SEQ_IDLE;
        cf_rail_prio = '0;
        cf_good_prio = '0;
        cf_off_delay = OFF_DELAY_RST;
        cf_req_blade = REQ_BLADE_RST;
        foreach (pr_status[o]) pr_status[o] = ST_UNKNOWN;

        // reset defaults: no priorities, blade enable required
        dir_rows.push_back(beat_row(mk_beat(FN_TICK, '0, 1'b0, '0, '0, '0, '0, 1'b0), 1'b1,
                                    '{16'h0000, 1'b0, ST_UNKNOWN, 1'b0, 1'b1}));
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_ON, '1, 1'b0, '0, '0, '0, '0, 1'b0), 1'b1,
                                    '{16'h0000, 1'b0, ST_UNKNOWN, 1'b0, 1'b0}));
        dir_rows.push_back(beat_row(mk_beat(FN_UNDEF_LO, '0, 1'b0, '0, '0, '0, '0, 1'b0), 1'b1,
                                    '{16'h0000, 1'b0, ST_UNKNOWN, 1'b0, 1'b0}));
        dir_rows.push_back(beat_row(mk_beat(FN_UNDEF_HI, '1, 1'b1, '1, '1, '1, '1, 1'b1), 1'b1,
                                    '{16'h0000, 1'b0, ST_UNKNOWN, 1'b0, 1'b0}));
        dir_rows.push_back(beat_row(mk_beat(FN_SET_STATUS, '0, 1'b0, '0, '0, 5'd16, '1, 1'b0),
                                    1'b1, '{16'h0000, 1'b0, ST_UNKNOWN, 1'b0, 1'b1}));
        dir_rows.push_back(beat_row(mk_beat(FN_SET_STATUS, '0, 1'b0, '0, '0, 5'd5, '1, 1'b0),
                                    1'b1, '{16'h0000, 1'b0, 3'd7, 1'b0, 1'b1}));
        dir_rows.push_back(beat_row(mk_beat(FN_WRITE_OK, '0, 1'b0, '0, '0, '0, '0, 1'b1), 1'b1,
                                    '{16'h0000, 1'b1, ST_UNKNOWN, 1'b0, 1'b1}));
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_ON, '1, 1'b1, '0, '0, 5'd5, '0, 1'b0),
                                    1'b0, '0));
        // rail e sits at level e mod 8, goods in reverse order; zero delay
        dir_rows.push_back(cfg_row(CFG_RAIL_PRIO, 48'o7654321076543210));
        dir_rows.push_back(cfg_row(CFG_GOOD_PRIO, 48'o0123456701234567));
        dir_rows.push_back(cfg_row(CFG_OFF_DELAY, '0));
        dir_rows.push_back(cfg_row(CFG_REQ_BLADE, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_LEVEL_ON, '0, 1'b0, '0, 3'd0, '0, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_LEVEL_ON, '0, 1'b0, '0, 3'd7, '0, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_SET_STATUS, '0, 1'b0, '0, '0, 5'd2, ST_DISABLED,
                                            1'b0), 1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_ON, 16'hAAAA, 1'b0, '0, '0, 5'd1, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_ON, '1, 1'b0, '0, '0, 5'd2, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_OFF, '0, 1'b0, '0, '0, 5'd2, '0, 1'b0),
                                    1'b0, '0));
        // power-on, level-on and write-ok ignored while the off sequence runs; set-status still applies
        dir_rows.push_back(beat_row(mk_beat(FN_POWER_ON, '1, 1'b1, '0, '0, 5'd0, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_LEVEL_ON, '0, 1'b0, '0, 3'd3, 5'd0, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_WRITE_OK, '0, 1'b0, '0, '0, 5'd0, '0, 1'b0),
                                    1'b0, '0));
        dir_rows.push_back(beat_row(mk_beat(FN_SET_STATUS, '0, 1'b0, '0, '0, 5'd4, 3'd3, 1'b0),
                                    1'b0, '0));
        // high goods hold the level and go unknown
        dir_rows.push_back(beat_row(mk_beat(FN_TICK, '0, 1'b0, '1, '0, 5'd1, '0, 1'b0),
                                    1'b0, '0));
        repeat (NUM_LEVELS) begin
            dir_rows.push_back(beat_row(mk_beat(FN_TICK, '0, 1'b0, '0, '0, 5'd1, '0, 1'b0),
                                        1'b0, '0));
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        foreach (dir_rows[i]) begin
            if (dir_rows[i].is_cfg) begin
                write_cfg(dir_rows[i].cfg_sel, dir_rows[i].cfg_val);
            end else begin
                maybe_idle();
                send_beat(dir_rows[i].beat, dir_rows[i].typed, dir_rows[i].want);
            end
        end

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            quiet = (ph == RAND_PHASES - 1);
            case (ph)
                0: begin
                    rp  = CFG_W'({PRIO_W{1'b1}});
                    gp  = CFG_W'({PRIO_W{1'b1}});
                    dly = DELAY_W'(1);
                    rb  = 1'b1;
                end
                1: begin
                    rp  = '0;
                    gp  = '0;
                    dly = '0;
                    rb  = 1'b0;
                end
                default: begin
                    rp  = CFG_W'({$urandom, $urandom});
                    gp  = CFG_W'({$urandom, $urandom});
                    dly = ($urandom_range(0, 3) == 0) ? DELAY_W'($urandom_range(0, 3))
                                                      : DELAY_W'($urandom_range(4, 16));
                    rb  = 1'($urandom_range(0, 1));
                end
            endcase
            write_cfg(CFG_RAIL_PRIO, rp);
            write_cfg(CFG_GOOD_PRIO, gp);
            write_cfg(CFG_OFF_DELAY, CFG_W'(dly));
            write_cfg(CFG_REQ_BLADE, CFG_W'(rb));
            for (int k = 0; k < BEATS_PER_PHASE; k++) begin
                if (ph == HOLD_PHASE && k == 40) hold_req = 1'b1;
                maybe_idle();
                send_beat(rand_beat(), 1'b0, '0);
            end
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (want_q.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (want_q.size() != 0) log_err("results still outstanding at end of run");
        if (err_cnt == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
